/* hw/rtl/tcpq_pkg.sv */
// ----------------------------------------------------------------------------
// Two-class priority queue package
// Shared widths, codes and the command and status bundles of the class rings.
// ----------------------------------------------------------------------------
package tcpq_pkg;

   localparam int unsigned CLASS_DEPTH = 16;
   localparam int unsigned AGE_W       = 8;
   localparam int unsigned PAYLOAD_W   = 16;
   localparam int unsigned WORD_W      = AGE_W + PAYLOAD_W;
   localparam int unsigned STATUS_W    = 2;
   localparam int unsigned TOTAL_W     = 6;

   localparam logic [AGE_W-1:0] THRESHOLD_RESET = 8'd59;

   typedef enum logic {
      KIND_INSERT = 1'b0,
      KIND_REMOVE = 1'b1
   } kind_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_INSERTED = 2'd0,
      STATUS_REMOVED  = 2'd1,
      STATUS_EMPTY    = 2'd2,
      STATUS_FULL     = 2'd3
   } rsp_status_type;

   typedef struct packed {
      logic              push;
      logic              pop;
      logic [WORD_W-1:0] wr_word;
   } ring_cmd_type;

   typedef struct packed {
      logic              full;
      logic              empty;
      logic [WORD_W-1:0] rd_word;
   } ring_stat_type;

endpackage

/* hw/rtl/tcpq_ring.sv */
// ----------------------------------------------------------------------------
// Class ring buffer
// One FIFO class: a synchronous entry memory with head and count registers.
// Read data of a pop is registered and valid in the cycle after the pop.
// ----------------------------------------------------------------------------
module tcpq_ring #(
   parameter int unsigned DEPTH = tcpq_pkg::CLASS_DEPTH
) (
   input  logic                         clock,
   input  logic                         reset,
   input  tcpq_pkg::ring_cmd_type       cmd,
   output tcpq_pkg::ring_stat_type      stat,
   output logic [$clog2(DEPTH+1)-1:0]   count
);

   localparam int unsigned IDXW = $clog2(DEPTH);
   localparam int unsigned CNTW = $clog2(DEPTH + 1);
   localparam int unsigned SUMW = CNTW + 1;

   logic [tcpq_pkg::WORD_W-1:0] mem [DEPTH];
   logic [tcpq_pkg::WORD_W-1:0] rd_word_ff;

   logic [IDXW-1:0] head_ff, head_in;
   logic [CNTW-1:0] count_ff, count_in;
   logic [SUMW-1:0] tail_sum;
   logic [IDXW-1:0] tail;
   logic            full, empty, do_push, do_pop;

   assign full    = (count_ff == CNTW'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = cmd.push && !full;
   assign do_pop  = cmd.pop && !empty;

   assign tail_sum = SUMW'(head_ff) + SUMW'(count_ff);

   always_comb begin
      if (tail_sum >= SUMW'(DEPTH)) begin
         tail = IDXW'(tail_sum - SUMW'(DEPTH));
      end else begin
         tail = IDXW'(tail_sum);
      end
   end

   always_comb begin
      head_in  = head_ff;
      count_in = count_ff;
      if (do_push) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop) begin
         count_in = count_ff - 1'b1;
         if (head_ff == IDXW'(DEPTH - 1)) begin
            head_in = '0;
         end else begin
            head_in = head_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[tail] <= cmd.wr_word;
      end
      if (do_pop) begin
         rd_word_ff <= mem[head_ff];
      end
   end

   assign stat.full    = full;
   assign stat.empty   = empty;
   assign stat.rd_word = rd_word_ff;
   assign count        = count_ff;

endmodule

/* hw/rtl/two_class_priority_queue.sv */
// ----------------------------------------------------------------------------
// Two-class strict-priority queue
// Requests on the req_ channel either insert an entry (tuser low) or remove
// the head entry (tuser high). An insert whose age is strictly above the
// threshold register joins the high class, any other joins the low class;
// each class keeps FIFO order in its own ring memory of CLASS_DEPTH entries.
// A remove returns the oldest high entry, else the oldest low entry.
// Every request yields exactly one response on the rsp_ channel, carrying a
// status code, the removed entry and the total entry count.
// An insert, a dropped insert or a remove from an empty queue answers in the
// cycle after acceptance and a new request can follow at once. A remove that
// returns an entry answers after a ring read in STATE_POP. The response sits
// in an output register; while a response waits, a new request is taken only
// in a cycle in which the receiver takes that response. Reset empties both
// classes at once and loads the threshold with 59. The user is to write the
// threshold through csr_wr_en and csr_wr_data only while idle (unenforced).
// ----------------------------------------------------------------------------
module two_class_priority_queue #(
   parameter int unsigned CLASS_DEPTH = tcpq_pkg::CLASS_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // age [7:0], payload [23:8]
   input  logic        req_tuser,   // kind [0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // out_age [7:0], out_payload [23:8],
                                    // total_entries [29:24], zero [31:30]
   output logic [1:0]  rsp_tuser,   // status [1:0]
   input  logic        csr_wr_en,
   input  logic [7:0]  csr_wr_data
);

   localparam int unsigned CNTW = $clog2(CLASS_DEPTH + 1);
   localparam int unsigned TOTW = CNTW + 1;

   typedef enum logic [1:0] {
      STATE_IDLE = 2'b01,
      STATE_POP  = 2'b10
   } state_type;

   state_type state_ff, state_in;
   logic      pop_high_ff, pop_high_in;

   logic [tcpq_pkg::AGE_W-1:0]     threshold_ff;
   logic                           rsp_valid_ff, rsp_valid_in;
   tcpq_pkg::rsp_status_type       status_ff, status_in;
   logic [tcpq_pkg::AGE_W-1:0]     age_ff, age_in;
   logic [tcpq_pkg::PAYLOAD_W-1:0] payload_ff, payload_in;
   logic [tcpq_pkg::TOTAL_W-1:0]   total_ff, total_in;

   tcpq_pkg::ring_cmd_type  high_cmd, low_cmd;
   tcpq_pkg::ring_stat_type high_stat, low_stat;
   logic [CNTW-1:0]         high_count, low_count;

   logic                           accept, is_high, target_full;
   logic [tcpq_pkg::AGE_W-1:0]     req_age;
   logic [tcpq_pkg::PAYLOAD_W-1:0] req_payload;
   logic [TOTW-1:0]                total_now;
   logic [tcpq_pkg::WORD_W-1:0]    pop_word;

   assign req_age     = req_tdata[7:0];
   assign req_payload = req_tdata[23:8];
   assign req_tready  = (state_ff == STATE_IDLE) && (!rsp_valid_ff || rsp_tready);
   assign accept      = req_tvalid && req_tready;
   assign is_high     = (req_age > threshold_ff);
   assign target_full = is_high ? high_stat.full : low_stat.full;
   assign total_now   = TOTW'(high_count) + TOTW'(low_count);
   assign pop_word    = pop_high_ff ? high_stat.rd_word : low_stat.rd_word;

   always_comb begin
      high_cmd.push    = 1'b0;
      high_cmd.pop     = 1'b0;
      high_cmd.wr_word = {req_age, req_payload};
      low_cmd.push     = 1'b0;
      low_cmd.pop      = 1'b0;
      low_cmd.wr_word  = {req_age, req_payload};
      state_in         = state_ff;
      pop_high_in      = pop_high_ff;
      rsp_valid_in     = rsp_valid_ff && !rsp_tready;
      status_in        = status_ff;
      age_in           = age_ff;
      payload_in       = payload_ff;
      total_in         = total_ff;
      unique case (state_ff)
         STATE_IDLE: begin
            if (accept) begin
               age_in     = '0;
               payload_in = '0;
               if (tcpq_pkg::kind_type'(req_tuser) == tcpq_pkg::KIND_INSERT) begin
                  rsp_valid_in = 1'b1;
                  if (target_full) begin
                     status_in = tcpq_pkg::STATUS_FULL;
                     total_in  = tcpq_pkg::TOTAL_W'(total_now);
                  end else begin
                     status_in     = tcpq_pkg::STATUS_INSERTED;
                     total_in      = tcpq_pkg::TOTAL_W'(total_now + 1'b1);
                     high_cmd.push = is_high;
                     low_cmd.push  = !is_high;
                  end
               end else if (!high_stat.empty) begin
                  high_cmd.pop = 1'b1;
                  pop_high_in  = 1'b1;
                  state_in     = STATE_POP;
               end else if (!low_stat.empty) begin
                  low_cmd.pop = 1'b1;
                  pop_high_in = 1'b0;
                  state_in    = STATE_POP;
               end else begin
                  rsp_valid_in = 1'b1;
                  status_in    = tcpq_pkg::STATUS_EMPTY;
                  total_in     = tcpq_pkg::TOTAL_W'(total_now);
               end
            end
         end
         STATE_POP: begin
            rsp_valid_in = 1'b1;
            status_in    = tcpq_pkg::STATUS_REMOVED;
            age_in       = pop_word[tcpq_pkg::WORD_W-1:tcpq_pkg::PAYLOAD_W];
            payload_in   = pop_word[tcpq_pkg::PAYLOAD_W-1:0];
            total_in     = tcpq_pkg::TOTAL_W'(total_now);
            state_in     = STATE_IDLE;
         end
         default: begin
            state_in = STATE_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= STATE_IDLE;
         rsp_valid_ff <= 1'b0;
         threshold_ff <= tcpq_pkg::THRESHOLD_RESET;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            threshold_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      pop_high_ff <= pop_high_in;
      status_ff   <= status_in;
      age_ff      <= age_in;
      payload_ff  <= payload_in;
      total_ff    <= total_in;
   end

   tcpq_ring #(
      .DEPTH (CLASS_DEPTH)
   ) u_high_ring (
      .clock (clock),
      .reset (reset),
      .cmd   (high_cmd),
      .stat  (high_stat),
      .count (high_count)
   );

   tcpq_ring #(
      .DEPTH (CLASS_DEPTH)
   ) u_low_ring (
      .clock (clock),
      .reset (reset),
      .cmd   (low_cmd),
      .stat  (low_stat),
      .count (low_count)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = status_ff;
   assign rsp_tdata  = {2'b00, total_ff, payload_ff, age_ff};

   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      (high_count <= CNTW'(CLASS_DEPTH)) && (low_count <= CNTW'(CLASS_DEPTH)))
      else $error("class count exceeds the ring depth");

   a_no_accept_in_pop: assert property (@(posedge clock) disable iff (reset)
      (state_ff == STATE_POP) |-> !req_tready)
      else $error("request accepted while a remove is reading memory");

   a_remove_reads: assert property (@(posedge clock) disable iff (reset)
      (accept && req_tuser && (total_now != '0)) |=> (state_ff == STATE_POP))
      else $error("remove from a nonempty queue did not read memory");

   a_pop_responds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == STATE_POP) |=>
         (rsp_valid_ff && (status_ff == tcpq_pkg::STATUS_REMOVED)))
      else $error("memory read did not produce a removed response");

endmodule
